/* rtl/core/cpid_pkg.sv */
// Package for the cascaded PID controller: widths, register indexes,
// request modes, sequencer states and the control bundle of the sequencer.
// Standalone; every other file in rtl/core imports it.
package cpid_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int ERR_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int INTG_W    = 32;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int OPND_W    = INTG_W;
  localparam int PROD_W    = GAIN_W + OPND_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int OUT_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_OUTER_PROP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUTER_INTG = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTER_DIFF = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INNER_PROP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INNER_INTG = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIFF = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CASCADE    = 3'd6;

  typedef enum logic [1:0] {
    MODE_ERR  = 2'd0,
    MODE_DIFF = 2'd1,
    MODE_BOTH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OPND_ERR  = 2'd0,
    OPND_INTG = 2'd1,
    OPND_DIFF = 2'd2
  } opnd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_CLIP,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic  in_ready;
    logic  update;
    logic  inner;
    opnd_t opnd;
    logic  acc_clr;
    logic  acc_add;
    logic  finish;
    logic  feed_inner;
    logic  out_valid;
  } ctrl_t;

endpackage

/* rtl/core/cascade_pid_controller.sv */
// Top level of the cascaded positional PID controller: configuration
// registers, stage state, update datapath and output register.
// Depends on cpid_pkg, cpid_fsm and cpid_mac.
//
// A request carries a mode in s_tuser and an error and an error difference
// in s_tdata; it yields exactly one result on the master side. The outer
// stage computes (kp*e + ki*integral + kd*diff) >> 8 in signed Q8.8 with
// floor rounding and 32-bit saturation; with cascade enabled its output,
// clipped to 16 bits, is the error of the inner stage, whose output is then
// the result. m_tuser flags any clipping of an error, integral or output
// during that request. All products go through one 16x32 signed multiplier
// in turn, so a stage steps through update, three products, sum and clip.
// The block takes one request at a time: it accepts the next request only
// after the result has been taken with m_tready. Gains and the cascade bit
// are to be written by the user through the cfg port only while no request
// is in flight; the block itself does not enforce it. An index above 6 is
// ignored. Reset clears gains, errors and integrals.
module cascade_pid_controller
  import cpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Request side.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [15:0] error_in, [31:16] diff_in
  input  logic [1:0]           s_tuser,   // [1:0] req_type
  // Result side.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,   // [31:0] drive
  output logic [0:0]           m_tuser,   // [0] saturated
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_t ctrl;
  logic  s_fire;

  // Gains and mode.
  logic signed [GAIN_W-1:0] outer_prop_gain, outer_intg_gain, outer_diff_gain;
  logic signed [GAIN_W-1:0] inner_prop_gain, inner_intg_gain, inner_diff_gain;
  logic                     cascade_enable;

  // Stage state.
  logic signed [ERR_W-1:0]  outer_error_now, inner_error_now;
  logic signed [INTG_W-1:0] outer_integral, inner_integral;

  // Request and working registers.
  mode_t                    mode;
  logic signed [ERR_W-1:0]  error_in, diff_in;
  logic signed [ERR_W-1:0]  casc_err;
  logic signed [ERR_W-1:0]  err_cur;
  logic signed [DIFF_W-1:0] diff_cur;
  logic        [OUT_W-1:0]  drive;
  logic                     saturated, saturated_next;

  // Update datapath.
  mode_t                    stage_mode;
  logic signed [ERR_W-1:0]  prev_err, src_err, err_new;
  logic signed [INTG_W-1:0] prev_intg, intg_new;
  logic signed [DIFF_W-1:0] diff_new, err_sum;
  logic signed [INTG_W:0]   intg_sum;
  logic                     err_clip, intg_clip;

  // Multiplier operands and outputs.
  logic signed [GAIN_W-1:0] mac_gain;
  logic signed [OPND_W-1:0] mac_opnd;
  logic        [OUT_W-1:0]  mac_result;
  logic                     mac_ovf;
  logic        [OUT_W-ERR_W:0] res_upper;
  logic                     casc_clip;
  logic signed [ERR_W-1:0]  casc_err_new;

  assign s_fire = s_tvalid && s_tready;

  cpid_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .cascade   (cascade_enable),
    .ctrl      (ctrl)
  );

  cpid_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .gain   (mac_gain),
    .opnd   (mac_opnd),
    .result (mac_result),
    .ovf    (mac_ovf)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_prop_gain <= '0;
      outer_intg_gain <= '0;
      outer_diff_gain <= '0;
      inner_prop_gain <= '0;
      inner_intg_gain <= '0;
      inner_diff_gain <= '0;
      cascade_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTER_PROP: outer_prop_gain <= cfg_data;
        REG_OUTER_INTG: outer_intg_gain <= cfg_data;
        REG_OUTER_DIFF: outer_diff_gain <= cfg_data;
        REG_INNER_PROP: inner_prop_gain <= cfg_data;
        REG_INNER_INTG: inner_intg_gain <= cfg_data;
        REG_INNER_DIFF: inner_diff_gain <= cfg_data;
        REG_CASCADE:    cascade_enable  <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Latch the request; the spare mode code behaves as error and difference.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      case (s_tuser)
        MODE_ERR:  mode <= MODE_ERR;
        MODE_DIFF: mode <= MODE_DIFF;
        default:   mode <= MODE_BOTH;
      endcase
      error_in <= s_tdata[15:0];
      diff_in  <= s_tdata[31:16];
    end
  end

  // One stage update: new error, difference and saturated integral. The
  // inner stage always updates by error, taking the clipped outer output.
  always_comb begin
    stage_mode = ctrl.inner ? MODE_ERR : mode;
    prev_err   = ctrl.inner ? inner_error_now : outer_error_now;
    prev_intg  = ctrl.inner ? inner_integral : outer_integral;
    src_err    = ctrl.inner ? casc_err : error_in;

    err_sum  = {prev_err[ERR_W-1], prev_err} + {diff_in[ERR_W-1], diff_in};
    err_clip = (err_sum[DIFF_W-1] != err_sum[DIFF_W-2]);

    case (stage_mode)
      MODE_ERR: begin
        err_new  = src_err;
        diff_new = {src_err[ERR_W-1], src_err} - {prev_err[ERR_W-1], prev_err};
        err_clip = 1'b0;
      end
      MODE_DIFF: begin
        if (err_clip) begin
          err_new = err_sum[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}}
                                      : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
          err_new = err_sum[ERR_W-1:0];
        end
        diff_new = {diff_in[ERR_W-1], diff_in};
      end
      default: begin
        err_new  = src_err;
        diff_new = {diff_in[ERR_W-1], diff_in};
        err_clip = 1'b0;
      end
    endcase

    intg_sum  = {prev_intg[INTG_W-1], prev_intg}
              + {{(INTG_W+1-ERR_W){err_new[ERR_W-1]}}, err_new};
    intg_clip = (intg_sum[INTG_W] != intg_sum[INTG_W-1]);
    if (intg_clip) begin
      intg_new = intg_sum[INTG_W] ? {1'b1, {(INTG_W-1){1'b0}}}
                                  : {1'b0, {(INTG_W-1){1'b1}}};
    end else begin
      intg_new = intg_sum[INTG_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctrl.opnd)
      OPND_INTG: begin
        mac_gain = ctrl.inner ? inner_intg_gain : outer_intg_gain;
        mac_opnd = ctrl.inner ? inner_integral : outer_integral;
      end
      OPND_DIFF: begin
        mac_gain = ctrl.inner ? inner_diff_gain : outer_diff_gain;
        mac_opnd = {{(OPND_W-DIFF_W){diff_cur[DIFF_W-1]}}, diff_cur};
      end
      default: begin
        mac_gain = ctrl.inner ? inner_prop_gain : outer_prop_gain;
        mac_opnd = {{(OPND_W-ERR_W){err_cur[ERR_W-1]}}, err_cur};
      end
    endcase
  end

  // Outer output clipped to 16 bits for the inner stage.
  always_comb begin
    res_upper = mac_result[OUT_W-1:ERR_W-1];
    casc_clip = !((&res_upper) || (~|res_upper));
    if (!casc_clip) begin
      casc_err_new = mac_result[ERR_W-1:0];
    end else if (mac_result[OUT_W-1]) begin
      casc_err_new = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      casc_err_new = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  always_comb begin
    saturated_next = saturated;
    if (s_fire) begin
      saturated_next = 1'b0;
    end else if (ctrl.update) begin
      saturated_next = saturated || err_clip || intg_clip;
    end else if (ctrl.finish) begin
      saturated_next = saturated || mac_ovf || (ctrl.feed_inner && casc_clip);
    end
  end

  // Stage state and flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_error_now <= '0;
      outer_integral  <= '0;
      inner_error_now <= '0;
      inner_integral  <= '0;
      saturated       <= 1'b0;
    end else begin
      saturated <= saturated_next;
      if (ctrl.update) begin
        if (ctrl.inner) begin
          inner_error_now <= err_new;
          inner_integral  <= intg_new;
        end else begin
          outer_error_now <= err_new;
          outer_integral  <= intg_new;
        end
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      err_cur  <= err_new;
      diff_cur <= diff_new;
    end
    if (ctrl.finish) begin
      drive <= mac_result;
      if (ctrl.feed_inner) casc_err <= casc_err_new;
    end
  end

  assign s_tready = ctrl.in_ready;
  assign m_tvalid = ctrl.out_valid;
  assign m_tdata  = drive;
  assign m_tuser  = saturated;

`ifndef SYNTHESIS
  // The block never holds a result while it takes a new request.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("request accepted while a result is pending");

  assert property (@(posedge clk) disable iff (rst) s_fire |=> !s_tready)
    else $error("ready stayed high after a request was taken");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready)
    else $error("block not ready after the result was taken");

  assert property (@(posedge clk) disable iff (rst)
    (ctrl.finish && !ctrl.feed_inner) |=> m_tvalid)
    else $error("last stage finished without presenting a result");
`endif

endmodule

/* rtl/core/cpid_mac.sv */
// Shared multiply-accumulate unit of the PID controller, with the final
// fixed-point shift and 32-bit saturation. Depends on cpid_pkg.
module cpid_mac
  import cpid_pkg::*;
(
  input  logic                     clk,
  input  ctrl_t                    ctrl,
  input  logic signed [GAIN_W-1:0] gain,
  input  logic signed [OPND_W-1:0] opnd,
  output logic        [OUT_W-1:0]  result,
  output logic                     ovf
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic        [ACC_W-OUT_W:0] upper;

  // The product is registered before it reaches the accumulator.
  always_ff @(posedge clk) begin
    prod <= gain * opnd;
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  always_comb begin
    shifted = acc >>> GAIN_FRAC_BITS;
    upper   = shifted[ACC_W-1:OUT_W-1];
    ovf     = !((&upper) || (~|upper));
    if (!ovf) begin
      result = shifted[OUT_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

endmodule

/* rtl/core/cpid_fsm.sv */
// Sequencer of the PID controller: steps each stage through update,
// three products, sum and clip, then hands the result out. Uses cpid_pkg.
module cpid_fsm
  import cpid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_ready,
  input  logic  cascade,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   inner, inner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inner <= 1'b0;
    end else begin
      state <= state_next;
      inner <= inner_next;
    end
  end

  always_comb begin
    state_next = state;
    inner_next = inner;
    unique case (state)
      ST_IDLE: begin
        inner_next = 1'b0;
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_SUM;
      ST_SUM:    state_next = ST_CLIP;
      ST_CLIP: begin
        if (!inner && cascade) begin
          inner_next = 1'b1;
          state_next = ST_UPDATE;
        end else begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.inner      = inner;
    ctrl.opnd       = OPND_ERR;
    unique case (state)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_UPDATE: ctrl.update   = 1'b1;
      ST_MUL_P:  ctrl.acc_clr  = 1'b1;
      ST_MUL_I: begin
        ctrl.opnd    = OPND_INTG;
        ctrl.acc_add = 1'b1;
      end
      ST_MUL_D: begin
        ctrl.opnd    = OPND_DIFF;
        ctrl.acc_add = 1'b1;
      end
      ST_SUM:    ctrl.acc_add = 1'b1;
      ST_CLIP: begin
        ctrl.finish     = 1'b1;
        ctrl.feed_inner = !inner && cascade;
      end
      ST_OUTPUT: ctrl.out_valid = 1'b1;
      default:   ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

/* tb/cascade_pid_controller_tb.sv */
// Self-checking testbench for cascade_pid_controller: directed corner requests,
// randomized gain settings and a saturation run, scored against a predictor.
// Depends on cpid_pkg and the controller RTL.
`timescale 1ns / 1ps

module cascade_pid_controller_tb;
  import cpid_pkg::*;

  // The request mode field has one spare code; the block treats it like MODE_BOTH.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Register index past the last register; writes to it must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
  // Number of mismatch lines printed before the log goes quiet.
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] err;
    logic [15:0] diff;
  } sample_t;

  typedef struct packed {
    logic [31:0] drive;
    logic        sat;
  } drive_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // [15:0] error_in, [31:16] diff_in
  logic [1:0]           s_tuser = '0;   // [1:0] req_type
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // [31:0] drive
  logic [0:0]           m_tuser;        // [0] saturated
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  cascade_pid_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state. Index 0 of the stage arrays is the outer stage, 1 the inner.
  // Gains are kept in register order: outer P, I, D, then inner P, I, D.
  logic signed [15:0] gain [6] = '{default: '0};
  logic               cascade_on = 1'b0;
  logic signed [15:0] err_now [2] = '{default: '0};
  logic signed [31:0] intg_sum [2] = '{default: '0};
  bit                 clipped;

  sample_t    samples_pending[$];
  drive_rec_t drive_due[$];
  int         open_requests = 0;
  int         mismatches = 0;
  // Idling density: 0 means never idle, otherwise a burst starts with odds 1 in N.
  int         idle_odds = 0;
  int         feed_pause = 0;
  int         take_pause = 0;

  // Saturate to a signed w-bit range and remember that clipping happened.
  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One PID stage: update its error and integral, then form the output from the Q8.8 gains.
  function automatic longint stage_out(int s, logic [1:0] kind, longint e_in, longint d_in);
    longint e, d, acc, t;
    if (kind == MODE_ERR) begin
      e = e_in;
      d = e - err_now[s];
    end else if (kind == MODE_DIFF) begin
      e = clamp(err_now[s] + d_in, ERR_W);
      d = d_in;
    end else begin
      // Both MODE_BOTH and the spare code take the two fields as given.
      e = e_in;
      d = d_in;
    end
    err_now[s] = e[15:0];
    t = clamp(intg_sum[s] + e, INTG_W);
    intg_sum[s] = t[31:0];
    acc = gain[3*s] * e + gain[3*s+1] * intg_sum[s] + gain[3*s+2] * d;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    return clamp(acc >>> GAIN_FRAC_BITS, OUT_W);
  endfunction

  // Work out the drive value and flag for one accepted request.
  function automatic void predict_drive(logic [1:0] kind, logic [15:0] e_raw,
                                        logic [15:0] d_raw);
    longint     y;
    drive_rec_t r;
    clipped = 1'b0;
    y = stage_out(0, kind, longint'($signed(e_raw)), longint'($signed(d_raw)));
    // The inner stage always runs by error, fed with the outer output cut to 16 bits.
    if (cascade_on)
      y = stage_out(1, MODE_ERR, clamp(y, ERR_W), 64'sd0);
    r.drive = y[31:0];
    r.sat = clipped;
    drive_due.push_back(r);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_sample(logic [1:0] kind, logic [15:0] e, logic [15:0] d);
    sample_t smp;
    smp.kind = kind;
    smp.err = e;
    smp.diff = d;
    samples_pending.push_back(smp);
    open_requests++;
  endfunction

  // Register write; the predictor copy follows once the block has taken it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OUTER_PROP, REG_OUTER_INTG, REG_OUTER_DIFF,
      REG_INNER_PROP, REG_INNER_INTG, REG_INNER_DIFF: begin
        gain[idx] = val;
      end
      REG_CASCADE: begin
        cascade_on = val[0];
      end
      default: begin
      end
    endcase
  endtask

  // Every request yields one result, so the block is idle once all results are
  // back; a few extra cycles let it settle into its idle state.
  task automatic wait_idle();
    while (open_requests != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver. Between requests it may hold off for a random burst; a
  // request once offered is held until the block takes it.
  always @(posedge clk) begin : request_driver
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        predict_drive(s_tuser, s_tdata[15:0], s_tdata[31:16]);
      if (!s_tvalid || s_tready) begin
        if (feed_pause == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          feed_pause = $urandom_range(1, 11);
        if (feed_pause != 0) begin
          feed_pause--;
          s_tvalid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          nxt = samples_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {nxt.diff, nxt.err};
          s_tuser <= nxt.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: scores each accepted result against the oldest prediction
  // and throttles m_tready in random bursts.
  always @(posedge clk) begin : result_monitor
    drive_rec_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_due.size() == 0) begin
          if (mismatches < REPORT_CAP)
            $display("%0t: result with nothing expected: drive %h saturated %b",
                     $time, m_tdata, m_tuser[0]);
          mismatches++;
        end else begin
          want = drive_due.pop_front();
          open_requests--;
          if (m_tdata !== want.drive) begin
            if (mismatches < REPORT_CAP)
              $display("%0t: drive expected %h, got %h", $time, want.drive, m_tdata);
            mismatches++;
          end
          if (m_tuser[0] !== want.sat) begin
            if (mismatches < REPORT_CAP)
              $display("%0t: saturated expected %b, got %b", $time, want.sat, m_tuser[0]);
            mismatches++;
          end
        end
      end
      if (take_pause == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        take_pause = $urandom_range(1, 11);
      if (take_pause != 0) begin
        take_pause--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int p;
    int i;
    int n;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_odds = 4;

    // All gains are zero out of reset: the drive is zero but state still moves.
    queue_sample(MODE_ERR, 16'h7FFF, 16'h1234);
    queue_sample(MODE_DIFF, 16'h0000, 16'h8000);
    wait_idle();

    // Single stage with unit proportional gain; the write to the unused index
    // must leave every gain alone.
    write_reg(REG_OUTER_PROP, 16'h0100);
    write_reg(REG_OUTER_INTG, 16'h0010);
    write_reg(REG_OUTER_DIFF, 16'h0080);
    write_reg(REG_CASCADE, 16'h0000);
    write_reg(REG_NONE, 16'hFFFF);
    queue_sample(MODE_ERR, 16'h8000, 16'h5A5A);
    // Error jumps from the most negative to the most positive value: a
    // difference that needs 17 bits.
    queue_sample(MODE_ERR, 16'h7FFF, 16'hA5A5);
    // A difference pushes the error past the top and then the bottom of 16 bits.
    queue_sample(MODE_DIFF, 16'h1111, 16'h7FFF);
    queue_sample(MODE_ERR, 16'h8000, 16'h0000);
    queue_sample(MODE_DIFF, 16'h2222, 16'h8000);
    queue_sample(MODE_BOTH, 16'h1234, 16'h8000);
    queue_sample(MODE_SPARE, 16'h7FFF, 16'h7FFF);
    queue_sample(MODE_DIFF, 16'h5555, 16'h0001);
    queue_sample(MODE_ERR, 16'h0000, 16'hFFFF);
    wait_idle();

    // Cascade on with a steep outer stage, so its output overruns the 16-bit
    // inner error in both directions. Only bit 0 of the cascade write counts.
    write_reg(REG_OUTER_PROP, 16'h7FFF);
    write_reg(REG_INNER_PROP, 16'h0100);
    write_reg(REG_INNER_INTG, 16'h8000);
    write_reg(REG_INNER_DIFF, 16'h7FFF);
    write_reg(REG_CASCADE, 16'hFFFF);
    queue_sample(MODE_ERR, 16'h7FFF, 16'h0000);
    queue_sample(MODE_ERR, 16'h8000, 16'h0000);
    queue_sample(MODE_BOTH, 16'h0000, 16'h0000);
    queue_sample(MODE_DIFF, 16'hFFFF, 16'h0100);
    queue_sample(MODE_SPARE, 16'h8000, 16'h7FFF);
    wait_idle();

    // Random settings, each with its own idling density and a batch of requests.
    for (p = 0; p < 8; p++) begin
      for (i = REG_OUTER_PROP; i <= REG_INNER_DIFF; i++)
        write_reg(i[REG_IDX_W-1:0], pick16());
      write_reg(REG_CASCADE, 16'($urandom));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_NONE, 16'($urandom));
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 3;
        2: idle_odds = 6;
        default: idle_odds = 12;
      endcase
      for (n = 0; n < 72; n++)
        queue_sample(2'($urandom_range(0, 3)), pick16(), pick16());
      wait_idle();
    end

    // Saturation run with no idling: a steady maximum error with steep outer
    // gains drives the outer output high, so the cascade input clips at once,
    // and the negative inner integral gain pulls the inner output down. A
    // short tail then swings the error to the other extreme.
    idle_odds = 0;
    write_reg(REG_OUTER_PROP, 16'h7FFF);
    write_reg(REG_OUTER_INTG, 16'h7FFF);
    write_reg(REG_OUTER_DIFF, pick16());
    write_reg(REG_INNER_PROP, pick16());
    write_reg(REG_INNER_INTG, 16'h8000);
    write_reg(REG_INNER_DIFF, pick16());
    write_reg(REG_CASCADE, 16'h0001);
    for (n = 0; n < 16; n++)
      queue_sample(2'($urandom_range(0, 3)), 16'h7FFF, 16'($urandom_range(0, 32767)));
    for (n = 0; n < 8; n++)
      queue_sample(2'($urandom_range(0, 3)), 16'h8000, pick16());
    wait_idle();
    repeat (16) @(posedge clk);

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // The slowest passing run ends well before this timeout.
  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/cpid_pkg.sv
rtl/core/cpid_mac.sv
rtl/core/cpid_fsm.sv
rtl/core/cascade_pid_controller.sv
tb/cascade_pid_controller_tb.sv
